// File: design/fcsp_pkg.sv
// fcsp_pkg: constants, codes and result type for the four-channel servo pulse generator
// used by four_channel_servo_pwm; no dependencies
`default_nettype none

package fcsp_pkg;

  localparam int unsigned POS_W      = 11;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned NUM_CH     = 4;

  localparam logic [CNT_W:0] PERIOD_TOP = 12'd2000;

  localparam logic [POS_W-1:0] BASE_MIN_RST  = 11'd120;
  localparam logic [POS_W-1:0] BASE_MAX_RST  = 11'd180;
  localparam logic [POS_W-1:0] LIFT_MIN_RST  = 11'd120;
  localparam logic [POS_W-1:0] LIFT_MAX_RST  = 11'd250;
  localparam logic [POS_W-1:0] REACH_MIN_RST = 11'd120;
  localparam logic [POS_W-1:0] REACH_MAX_RST = 11'd250;
  localparam logic [POS_W-1:0] GRIP_MIN_RST  = 11'd100;
  localparam logic [POS_W-1:0] GRIP_MAX_RST  = 11'd250;

  localparam logic [POS_W-1:0] BASE_POS_RST  = 11'd150;
  localparam logic [POS_W-1:0] LIFT_POS_RST  = 11'd200;
  localparam logic [POS_W-1:0] REACH_POS_RST = 11'd180;
  localparam logic [POS_W-1:0] GRIP_POS_RST  = 11'd150;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_SET_BASE   = 3'd1,
    OP_LIFT_UP    = 3'd2,
    OP_LIFT_DOWN  = 3'd3,
    OP_REACH_OUT  = 3'd4,
    OP_REACH_IN   = 3'd5,
    OP_GRIP_CLOSE = 3'd6,
    OP_GRIP_OPEN  = 3'd7
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_MIN  = 4'd0,
    REG_BASE_MAX  = 4'd1,
    REG_LIFT_MIN  = 4'd2,
    REG_LIFT_MAX  = 4'd3,
    REG_REACH_MIN = 4'd4,
    REG_REACH_MAX = 4'd5,
    REG_GRIP_MIN  = 4'd6,
    REG_GRIP_MAX  = 4'd7
  } cfg_reg_t;

  // pin bit order: base, lift, grip, reach
  typedef struct packed {
    logic [NUM_CH-1:0] pins;
    logic [POS_W-1:0]  base_width;
    logic [POS_W-1:0]  lift_width;
    logic [POS_W-1:0]  reach_width;
    logic [POS_W-1:0]  grip_width;
  } result_t;

endpackage

`default_nettype wire

// File: design/four_channel_servo_pwm.sv
// four_channel_servo_pwm: four-channel servo pulse generator with clamped positions
// depends on fcsp_pkg
//
// usage:
//   input beats (opcode, amount) arrive on in_valid / in_stall; a tick opcode advances
//   the period counter (1..2000 then 0) and samples all four pin levels, the other
//   opcodes set or step one channel position, clamped to that channel's limits
//   output beats carry the four pin levels and the four positions after the step,
//   exactly one output beat for each input beat, in order
//   limits are written on cfg_write / cfg_index / cfg_data; the user keeps this to times
//   when no beat is in flight, the block does not enforce it; an index beyond 7 is ignored
//   and a limit write does not re-clamp a position; throughput: one beat per cycle while
//   out_stall is low, set by the single compute stage feeding the output register
//   when out_stall is high the output register holds and one more beat lands in a
//   skid register; in_stall then rises until the receiver drains it
//   reset (rst, synchronous): limits and positions go to their defaults, counter to
//   zero, internal pin levels high, both output registers empty
`default_nettype none

module four_channel_servo_pwm
  import fcsp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire logic [2:0]           opcode,
  input  wire logic [POS_W-1:0]     amount,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      logic                 base_pin,
  output      logic                 lift_pin,
  output      logic                 grip_pin,
  output      logic                 reach_pin,
  output      logic [POS_W-1:0]     base_width,
  output      logic [POS_W-1:0]     lift_width,
  output      logic [POS_W-1:0]     reach_width,
  output      logic [POS_W-1:0]     grip_width,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [POS_W-1:0]     cfg_data
);

  logic [POS_W-1:0] base_min, base_max, lift_min, lift_max;
  logic [POS_W-1:0] reach_min, reach_max, grip_min, grip_max;
  logic [CNT_W-1:0] period_count, period_count_next;
  logic [POS_W-1:0] base_pos, lift_pos, reach_pos, grip_pos;
  logic [POS_W-1:0] base_pos_next, lift_pos_next, reach_pos_next, grip_pos_next;
  logic [NUM_CH-1:0] pin_levels, pin_levels_next;

  result_t out_data, skid_data, result;
  logic    skid_valid;
  logic    in_accept, out_accept, load_out;

  function automatic logic [POS_W-1:0] clamp_high_first(
    input logic [POS_W:0]   v,
    input logic [POS_W-1:0] lo,
    input logic [POS_W-1:0] hi
  );
    logic [POS_W-1:0] r;
    if (v > {1'b0, hi}) r = hi;
    else if (v < {1'b0, lo}) r = lo;
    else r = v[POS_W-1:0];
    return r;
  endfunction

  function automatic logic [POS_W-1:0] move_up(
    input logic [POS_W-1:0] pos,
    input logic [POS_W-1:0] step,
    input logic [POS_W-1:0] lo,
    input logic [POS_W-1:0] hi
  );
    return clamp_high_first({1'b0, pos} + {1'b0, step}, lo, hi);
  endfunction

  function automatic logic [POS_W-1:0] move_down(
    input logic [POS_W-1:0] pos,
    input logic [POS_W-1:0] step,
    input logic [POS_W-1:0] lo,
    input logic [POS_W-1:0] hi
  );
    logic [POS_W-1:0] v;
    v = (step > pos) ? '0 : pos - step;
    return clamp_high_first({1'b0, v}, lo, hi);
  endfunction

  assign in_stall   = skid_valid;
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign load_out   = !out_valid || out_accept;

  // per-beat compute
  always_comb begin
    logic [CNT_W:0] cnt_inc;
    cnt_inc           = {1'b0, period_count} + 1'b1;
    period_count_next = period_count;
    pin_levels_next   = pin_levels;
    base_pos_next     = base_pos;
    lift_pos_next     = lift_pos;
    reach_pos_next    = reach_pos;
    grip_pos_next     = grip_pos;
    unique case (opcode_t'(opcode))
      OP_TICK: begin
        period_count_next = (cnt_inc > PERIOD_TOP) ? '0 : cnt_inc[CNT_W-1:0];
        pin_levels_next[0] = period_count_next < base_pos;
        pin_levels_next[1] = period_count_next < lift_pos;
        pin_levels_next[2] = period_count_next < grip_pos;
        pin_levels_next[3] = period_count_next < reach_pos;
      end
      OP_SET_BASE: begin
        if (amount < base_min) base_pos_next = base_min;
        else if (amount > base_max) base_pos_next = base_max;
        else base_pos_next = amount;
      end
      OP_LIFT_UP:    lift_pos_next  = move_up(lift_pos, amount, lift_min, lift_max);
      OP_LIFT_DOWN:  lift_pos_next  = move_down(lift_pos, amount, lift_min, lift_max);
      OP_REACH_OUT:  reach_pos_next = move_up(reach_pos, amount, reach_min, reach_max);
      OP_REACH_IN:   reach_pos_next = move_down(reach_pos, amount, reach_min, reach_max);
      OP_GRIP_CLOSE: grip_pos_next  = move_down(grip_pos, amount, grip_min, grip_max);
      OP_GRIP_OPEN:  grip_pos_next  = move_up(grip_pos, amount, grip_min, grip_max);
      default: ;
    endcase
    result.pins        = pin_levels_next;
    result.base_width  = base_pos_next;
    result.lift_width  = lift_pos_next;
    result.reach_width = reach_pos_next;
    result.grip_width  = grip_pos_next;
  end

  // channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      period_count <= '0;
      pin_levels   <= '1;
      base_pos     <= BASE_POS_RST;
      lift_pos     <= LIFT_POS_RST;
      reach_pos    <= REACH_POS_RST;
      grip_pos     <= GRIP_POS_RST;
    end else if (in_accept) begin
      period_count <= period_count_next;
      pin_levels   <= pin_levels_next;
      base_pos     <= base_pos_next;
      lift_pos     <= lift_pos_next;
      reach_pos    <= reach_pos_next;
      grip_pos     <= grip_pos_next;
    end
  end

  // limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_min  <= BASE_MIN_RST;
      base_max  <= BASE_MAX_RST;
      lift_min  <= LIFT_MIN_RST;
      lift_max  <= LIFT_MAX_RST;
      reach_min <= REACH_MIN_RST;
      reach_max <= REACH_MAX_RST;
      grip_min  <= GRIP_MIN_RST;
      grip_max  <= GRIP_MAX_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BASE_MIN:  base_min  <= cfg_data;
        REG_BASE_MAX:  base_max  <= cfg_data;
        REG_LIFT_MIN:  lift_min  <= cfg_data;
        REG_LIFT_MAX:  lift_max  <= cfg_data;
        REG_REACH_MIN: reach_min <= cfg_data;
        REG_REACH_MAX: reach_max <= cfg_data;
        REG_GRIP_MIN:  grip_min  <= cfg_data;
        REG_GRIP_MAX:  grip_max  <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register and skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (load_out) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_accept;
        end
      end else if (in_accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= skid_valid ? skid_data : result;
    end
    if (in_accept && !load_out) begin
      skid_data <= result;
    end
  end

  assign base_pin    = out_data.pins[0];
  assign lift_pin    = out_data.pins[1];
  assign grip_pin    = out_data.pins[2];
  assign reach_pin   = out_data.pins[3];
  assign base_width  = out_data.base_width;
  assign lift_width  = out_data.lift_width;
  assign reach_width = out_data.reach_width;
  assign grip_width  = out_data.grip_width;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while output register is empty");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, period_count} <= PERIOD_TOP)
    else $error("period counter beyond top");

  a_tick_moves_count: assert property (@(posedge clk) disable iff (rst)
    in_accept && (opcode == OP_TICK) |=> period_count != $past(period_count))
    else $error("tick did not advance period counter");

  a_pins_hold: assert property (@(posedge clk) disable iff (rst)
    in_accept && (opcode != OP_TICK) |=> pin_levels == $past(pin_levels))
    else $error("pin levels changed on a move beat");

  a_beat_lands: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted beat not held in output stage");

endmodule

`default_nettype wire
